// ===== rtl/pec_pkg.sv =====
// Shared types, constants and helper functions for the polynomial easing curve.
// Used by the stream interfaces, the divider and the top level; depends on nothing.
`default_nettype none

package pec_pkg;

  // Payload widths.
  localparam int unsigned POS_W  = 16;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned PROD_W = 48;
  localparam int unsigned NUM_W  = 49;
  localparam int unsigned QUO_W  = 34;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE_KIND = 2'd0,
    CFG_WIDE_MODE  = 2'd1
  } pec_cfg_idx_t;

  typedef enum logic [2:0] {
    CURVE_IN_OUT_QUAD  = 3'd0,
    CURVE_IN_OUT_CUBIC = 3'd1,
    CURVE_OUT_QUAD     = 3'd2,
    CURVE_IN_CUBIC     = 3'd3,
    CURVE_OUT_CUBIC    = 3'd4
  } pec_curve_t;

  // Full-scale values and the mirror point of the in-out curves.
  localparam logic [VAL_W-1:0] MAX_WIDE        = 16'hFFFF;
  localparam logic [VAL_W-1:0] MAX_NARROW      = 16'h00FF;
  localparam logic [VAL_W-1:0] MID_WIDE        = 16'd32768;
  localparam logic [VAL_W-1:0] MID_NARROW      = 16'd128;

  // Rounding offsets: half of MAX and half of MAX squared, rounded down.
  localparam logic [NUM_W-1:0] RND_WIDE        = 49'd32767;
  localparam logic [NUM_W-1:0] RND_NARROW      = 49'd127;
  localparam logic [NUM_W-1:0] RND_SQ_WIDE     = 49'd2147418112;
  localparam logic [NUM_W-1:0] RND_SQ_NARROW   = 49'd32512;

  // Per-word control that travels down the pipeline next to the data.
  typedef struct packed {
    logic             wide;    // 16-bit curve
    logic             cubic;   // divide by MAX squared
    logic             mirror;  // result is MAX minus quotient
    logic             zero;    // unused curve code, result is zero
    logic [1:0]       ksh;     // numerator scale: shift by 0, 1 or 2
    logic [VAL_W-1:0] q_byp;   // quotient of the first division
  } pec_side_t;

  // High digit of a remainder word in base 256 or base 65536.
  function automatic logic [QUO_W-1:0] pec_hi(input logic [QUO_W-1:0] r, input logic wide);
    return wide ? (r >> 16) : (r >> 8);
  endfunction

  // Low digit of a remainder word in base 256 or base 65536.
  function automatic logic [QUO_W-1:0] pec_lo(input logic [QUO_W-1:0] r, input logic wide);
    return wide ? {18'd0, r[15:0]} : {26'd0, r[7:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pec_stream_if.sv =====
// Valid/ready stream interfaces for the position words and the eased result words.
// Depends on pec_pkg for the payload widths.
`default_nettype none

interface pec_in_if import pec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface pec_out_if import pec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/polynomial_easing_curve.sv =====
// Top level of the polynomial easing curve: decode, multiply, two divisions, mirror.
// Depends on pec_pkg, pec_stream_if and pec_divider.
`default_nettype none

// Maps each position word to its eased value on the selected curve, rounding to
// nearest. The block takes one word per clock while its output is not stalled: four
// stages select the operand, square it, cube it and add the rounding offset, then
// two five-stage divide-by-MAX pipelines form the quotient (quadratic curves use
// the first division only), and one stage mirrors the result into the output
// register. A stalled output holds the whole pipeline in place. Curve codes 5 to 7
// return zero. The user must write curve_kind and wide_mode through cfg_we, cfg_index
// and cfg_data only while no word is in flight; the block does not enforce this.
module polynomial_easing_curve import pec_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pec_in_if.sink                     in_ch,
  pec_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]        curve_kind_r;
  logic              wide_mode_r;

  logic              adv;
  logic              v1_r, v2_r, v3_r, v4_r;
  pec_side_t         side1_r, side2_r, side3_r, side4_r;
  pec_side_t         side1_nxt;
  logic [POS_W-1:0]  x1_r, x2_r;
  logic [POS_W-1:0]  x1_nxt;
  logic [31:0]       sq2_r;
  logic [PROD_W-1:0] t3_r;
  logic [NUM_W-1:0]  num4_r;
  logic [NUM_W-1:0]  num4_nxt;

  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  top;
  logic [VAL_W-1:0]  rev_pos;
  logic              below_mid;

  logic              va;
  pec_side_t         side_a;
  pec_side_t         side_b_in;
  logic [QUO_W-1:0]  quo_a;
  logic              vb;
  pec_side_t         side_b;
  logic [QUO_W-1:0]  quo_b;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [VAL_W-1:0]  out_value_nxt;
  logic [VAL_W-1:0]  quo_fin;
  logic [VAL_W-1:0]  top_fin;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_kind_r <= 3'd0;
      wide_mode_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURVE_KIND: curve_kind_r <= cfg_data;
        CFG_WIDE_MODE:  wide_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is empty or being taken.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: pick the operand (position or its distance to MAX) and the curve controls.
  always_comb begin
    top       = wide_mode_r ? MAX_WIDE : MAX_NARROW;
    pos       = wide_mode_r ? in_ch.position : {8'd0, in_ch.position[7:0]};
    rev_pos   = top - pos;
    below_mid = pos < (wide_mode_r ? MID_WIDE : MID_NARROW);
    side1_nxt = '{wide: wide_mode_r, cubic: 1'b0, mirror: 1'b0, zero: 1'b0,
                  ksh: 2'd0, q_byp: '0};
    x1_nxt    = pos;
    unique case (curve_kind_r)
      CURVE_IN_OUT_QUAD: begin
        x1_nxt           = below_mid ? pos : rev_pos;
        side1_nxt.mirror = !below_mid;
        side1_nxt.ksh    = 2'd1;
      end
      CURVE_IN_OUT_CUBIC: begin
        x1_nxt           = below_mid ? pos : rev_pos;
        side1_nxt.mirror = !below_mid;
        side1_nxt.cubic  = 1'b1;
        side1_nxt.ksh    = 2'd2;
      end
      CURVE_OUT_QUAD: begin
        x1_nxt           = rev_pos;
        side1_nxt.mirror = 1'b1;
      end
      CURVE_IN_CUBIC: begin
        x1_nxt           = pos;
        side1_nxt.cubic  = 1'b1;
      end
      CURVE_OUT_CUBIC: begin
        x1_nxt           = rev_pos;
        side1_nxt.mirror = 1'b1;
        side1_nxt.cubic  = 1'b1;
      end
      default: begin
        x1_nxt           = '0;
        side1_nxt.zero   = 1'b1;
      end
    endcase
  end

  // Stage 4 input: scale the power and add half the divisor for rounding.
  always_comb begin
    num4_nxt = ({1'b0, t3_r} << side3_r.ksh)
             + (side3_r.cubic ? (side3_r.wide ? RND_SQ_WIDE : RND_SQ_NARROW)
                              : (side3_r.wide ? RND_WIDE : RND_NARROW));
  end

  // Front stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Front stage data: operand, square, cube, numerator.
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= x1_nxt;
      side1_r <= side1_nxt;
      x2_r    <= x1_r;
      sq2_r   <= {16'd0, x1_r} * {16'd0, x1_r};
      side2_r <= side1_r;
      t3_r    <= side2_r.cubic ? ({16'd0, sq2_r} * {32'd0, x2_r}) : {16'd0, sq2_r};
      side3_r <= side2_r;
      num4_r  <= num4_nxt;
      side4_r <= side3_r;
    end
  end

  // First division by MAX: the final quotient for the quadratic curves.
  pec_divider u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v4_r),
    .in_side  (side4_r),
    .in_num   (num4_r),
    .out_vld  (va),
    .out_side (side_a),
    .out_quo  (quo_a)
  );

  // Keep the first quotient alongside for the quadratic curves.
  always_comb begin
    side_b_in       = side_a;
    side_b_in.q_byp = quo_a[VAL_W-1:0];
  end

  // Second division by MAX completes the division by MAX squared.
  pec_divider u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (va),
    .in_side  (side_b_in),
    .in_num   ({{(NUM_W-QUO_W){1'b0}}, quo_a}),
    .out_vld  (vb),
    .out_side (side_b),
    .out_quo  (quo_b)
  );

  // Mirror for the out and upper in-out halves; unused codes give zero.
  always_comb begin
    quo_fin = side_b.cubic ? quo_b[VAL_W-1:0] : side_b.q_byp;
    top_fin = side_b.wide ? MAX_WIDE : MAX_NARROW;
    priority if (side_b.zero) begin
      out_value_nxt = '0;
    end else if (side_b.mirror) begin
      out_value_nxt = top_fin - quo_fin;
    end else begin
      out_value_nxt = quo_fin;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.eased_value = out_value_r;

endmodule

`default_nettype wire

// ===== rtl/pec_divider.sv =====
// Pipelined floor division by MAX (255 or 65535) in five stages, four digit
// reductions and one final correction. Depends on pec_pkg.
`default_nettype none

module pec_divider import pec_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire pec_side_t        in_side,
  input  wire logic [NUM_W-1:0] in_num,
  output logic                  out_vld,
  output pec_side_t             out_side,
  output logic [QUO_W-1:0]      out_quo
);

  // With N = a*2^n + b and MAX = 2^n - 1, N = a*MAX + (a + b). Each stage adds
  // a to the quotient and carries a + b on as the new remainder.
  logic             vld_r  [0:4];
  pec_side_t        side_r [0:4];
  logic [QUO_W-1:0] quo_r  [0:3];
  logic [QUO_W-1:0] rem_r  [0:3];
  logic [QUO_W-1:0] quo_fin_r;

  logic [NUM_W-1:0] hi0_wide;
  logic [QUO_W-1:0] hi0;
  logic [QUO_W-1:0] lo0;
  logic [QUO_W-1:0] hi_s   [1:3];
  logic [QUO_W-1:0] lo_s   [1:3];
  logic [QUO_W-1:0] max_fin;

  // First reduction straight from the wide numerator; its high digit fits 34 bits.
  always_comb begin
    hi0_wide = in_side.wide ? (in_num >> 16) : (in_num >> 8);
    hi0      = hi0_wide[QUO_W-1:0];
    lo0      = in_side.wide ? {18'd0, in_num[15:0]} : {26'd0, in_num[7:0]};
  end

  // Digits for the three following reductions.
  always_comb begin
    for (int i = 1; i < 4; i++) begin
      hi_s[i] = pec_hi(rem_r[i-1], side_r[i-1].wide);
      lo_s[i] = pec_lo(rem_r[i-1], side_r[i-1].wide);
    end
  end

  // The remainder is now below twice MAX, so one compare finishes the quotient.
  assign max_fin = side_r[3].wide ? {18'd0, MAX_WIDE} : {18'd0, MAX_NARROW};

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < 5; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      quo_r[0]  <= hi0;
      rem_r[0]  <= hi0 + lo0;
      for (int i = 1; i < 4; i++) begin
        side_r[i] <= side_r[i-1];
        quo_r[i]  <= quo_r[i-1] + hi_s[i];
        rem_r[i]  <= hi_s[i] + lo_s[i];
      end
      side_r[4] <= side_r[3];
      quo_fin_r <= (rem_r[3] >= max_fin) ? quo_r[3] + 34'd1 : quo_r[3];
    end
  end

  assign out_vld  = vld_r[4];
  assign out_side = side_r[4];
  assign out_quo  = quo_fin_r;

endmodule

`default_nettype wire
